// ===== rtl/core/voe_pkg.sv =====
// Package: types and constants for the VM opcode execute unit.
package voe_pkg;
  localparam int StackDepthDef = 16;
  localparam int MemoryBytesDef = 4096;
  localparam int QueueDepth = 2;
  localparam logic [11:0] PcReset = 12'd512;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLS, OP_RET, OP_JP, OP_CALL, OP_SE, OP_SNE, OP_LD,
    OP_ALU, OP_IDX, OP_IDXADD, OP_JPV0, OP_RND, OP_TMR, OP_STORE, OP_LOAD
  } op_e;

  typedef enum logic [1:0] {ST_IDLE, ST_MEM, ST_WAIT, ST_DONE} state_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] instruction_word;
    logic [7:0]  random_byte;
    logic [15:0] key_states;
    logic [11:0] load_address;
    logic [7:0]  load_data;
  } in_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [15:0] index_value;
    logic        matched;
    logic        clear_display;
    logic [7:0]  sound_level;
    logic        stack_fault;
  } out_t;

  typedef struct packed {
    op_e         op;
    logic        load;
    logic        matched;
    in_t         item;
  } cmd_t;
endpackage

// ===== rtl/core/voe_front.sv =====
// Front: accepts items, classifies the opcode, and queues commands.
module voe_front import voe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  input  logic pop_i,
  output logic cmd_valid_o,
  output cmd_t cmd_o
);
  cmd_t q_q [QueueDepth];
  logic [1:0] cnt_q, cnt_d;
  logic rd_q, wr_q;
  cmd_t c;
  logic [15:0] w;
  logic push;

  assign busy = (cnt_q == 2'(QueueDepth));
  assign push = start && !busy;
  assign w = in_i.instruction_word;

  always_comb begin
    c.item = in_i;
    c.load = in_i.kind;
    c.op = OP_NONE;
    unique case (w[15:12])
      4'h0: c.op = (w == 16'h00e0) ? OP_CLS : (w == 16'h00ee) ? OP_RET : OP_NONE;
      4'h1: c.op = OP_JP;
      4'h2: c.op = OP_CALL;
      4'h3, 4'h5: c.op = OP_SE;
      4'h4: c.op = OP_SNE;
      4'h6, 4'h7: c.op = OP_LD;
      4'h8: c.op = (w[3:0] <= 4'h7 || w[3:0] == 4'he) ? OP_ALU : OP_NONE;
      4'h9: c.op = (w[3:0] == 4'h0) ? OP_SNE : OP_NONE;
      4'ha: c.op = OP_IDX;
      4'hb: c.op = OP_JPV0;
      4'hc: c.op = OP_RND;
      4'he: c.op = (w[7:0] == 8'h9e || w[7:0] == 8'ha1) ? OP_SE : OP_NONE;
      4'hf: begin
        case (w[7:0])
          8'h07, 8'h15, 8'h18: c.op = OP_TMR;
          8'h1e: c.op = OP_IDXADD;
          8'h55: c.op = OP_STORE;
          8'h65: c.op = OP_LOAD;
          default: c.op = OP_NONE;
        endcase
      end
      default: c.op = OP_NONE;
    endcase
    if (in_i.kind) c.op = OP_NONE;
    c.matched = !in_i.kind && (c.op != OP_NONE);
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) cnt_d = cnt_q + 2'd1;
    if (!push && pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= c;
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = q_q[rd_q];
endmodule

// ===== rtl/core/voe_back.sv =====
// Back: architectural state, data memory and the execute sequencer.
module voe_back import voe_pkg::*; #(
  parameter int STACK_DEPTH = StackDepthDef,
  parameter int MEMORY_BYTES = MemoryBytesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic pop_o,
  output logic done_o,
  output out_t result_o
);
  localparam int SpW = $clog2(STACK_DEPTH + 1);
  localparam int SiW = $clog2(STACK_DEPTH);
  localparam int AW = $clog2(MEMORY_BYTES);

  state_e st_q, st_d;
  logic [11:0] pc_q, pc_d;
  logic [7:0] v_q [16];
  logic [15:0] i_q, i_d;
  logic [11:0] stk_q [STACK_DEPTH];
  logic [SpW-1:0] sp_q, sp_d;
  logic [7:0] dt_q, dt_d, st8_q, st8_d;
  logic [7:0] mem_q [MEMORY_BYTES];
  logic [7:0] rdata_q;
  logic [3:0] k_q, k_d, kw_q;
  logic ldw_q;
  logic fault_d, fault_q, stk_we, reg_we, vf_we;
  logic [3:0] reg_a;
  logic [7:0] reg_v, vf_v;
  logic mem_we;
  logic [AW-1:0] mem_a;
  logic [7:0] mem_v;
  logic [11:0] ret_a;

  logic [15:0] w;
  logic [3:0] x, y;
  logic [7:0] vx, vy, nn;
  logic [8:0] sum;
  logic held;
  logic [11:0] pc2;

  assign w = cmd_i.item.instruction_word;
  assign x = w[11:8];
  assign y = w[7:4];
  assign nn = w[7:0];
  assign vx = v_q[x];
  assign vy = v_q[y];
  assign sum = {1'b0, vx} + {1'b0, vy};
  assign held = cmd_i.item.key_states[vx[3:0]] && (vx[7:4] == 4'd0);
  assign pc2 = pc_q + 12'd2;
  assign ret_a = stk_q[SiW'(sp_q - SpW'(1))];

  always_comb begin
    st_d = st_q; pc_d = pc_q; i_d = i_q; sp_d = sp_q; dt_d = dt_q; st8_d = st8_q;
    k_d = k_q; fault_d = fault_q; pop_o = 1'b0; done_o = 1'b0;
    stk_we = 1'b0; reg_we = 1'b0; vf_we = 1'b0; reg_a = x; reg_v = '0; vf_v = '0;
    mem_we = 1'b0; mem_a = AW'(12'(i_q[11:0] + 12'(k_q))); mem_v = v_q[k_q];
    unique case (st_q)
      ST_IDLE: if (cmd_valid_i) begin
        fault_d = 1'b0;
        k_d = '0;
        if (cmd_i.load) begin
          mem_we = 1'b1;
          mem_a = AW'(cmd_i.item.load_address);
          mem_v = cmd_i.item.load_data;
          st_d = ST_DONE;
        end else begin
          pc_d = pc2;
          st_d = ST_DONE;
          unique case (cmd_i.op)
            OP_RET: if (sp_q == '0) fault_d = 1'b1;
                    else begin sp_d = sp_q - SpW'(1); pc_d = ret_a; end
            OP_JP: pc_d = w[11:0];
            OP_CALL: if (sp_q >= SpW'(STACK_DEPTH)) fault_d = 1'b1;
                     else begin stk_we = 1'b1; sp_d = sp_q + SpW'(1); pc_d = w[11:0]; end
            OP_SE: begin
              if (w[15:12] == 4'h3 && vx == nn) pc_d = pc_q + 12'd4;
              if (w[15:12] == 4'h5 && vx == vy) pc_d = pc_q + 12'd4;
              if (w[15:12] == 4'he && (nn == 8'h9e ? held : !held)) pc_d = pc_q + 12'd4;
            end
            OP_SNE: begin
              if (w[15:12] == 4'h4 && vx != nn) pc_d = pc_q + 12'd4;
              if (w[15:12] == 4'h9 && vx != vy) pc_d = pc_q + 12'd4;
            end
            OP_LD: begin
              reg_we = 1'b1;
              reg_v = w[12] ? 8'(vx + nn) : nn;
            end
            OP_ALU: begin
              reg_we = 1'b1;
              case (w[3:0])
                4'h0: reg_v = vy;
                4'h1: reg_v = vx | vy;
                4'h2: reg_v = vx & vy;
                4'h3: reg_v = vx ^ vy;
                4'h4: begin reg_v = sum[7:0]; vf_we = 1'b1; vf_v = {7'd0, sum[8]}; end
                4'h5: begin reg_v = vx - vy; vf_we = 1'b1; vf_v = {7'd0, vx >= vy}; end
                4'h6: begin reg_v = {1'b0, vy[7:1]}; vf_we = 1'b1; vf_v = {7'd0, vy[0]}; end
                4'h7: begin reg_v = vy - vx; vf_we = 1'b1; vf_v = {7'd0, vy >= vx}; end
                default: begin reg_v = {vy[6:0], 1'b0}; vf_we = 1'b1; vf_v = {7'd0, vy[7]}; end
              endcase
            end
            OP_IDX: i_d = {4'd0, w[11:0]};
            OP_IDXADD: i_d = i_q + {8'd0, vx};
            OP_JPV0: pc_d = w[11:0] + {4'd0, v_q[0]};
            OP_RND: begin reg_we = 1'b1; reg_v = cmd_i.item.random_byte & nn; end
            OP_TMR: begin
              if (nn == 8'h07) begin reg_we = 1'b1; reg_v = dt_q; end
              if (nn == 8'h15) dt_d = vx;
              if (nn == 8'h18) st8_d = vx;
            end
            OP_STORE, OP_LOAD: st_d = ST_MEM;
            default: ;
          endcase
        end
      end
      ST_MEM: begin
        if (cmd_i.op == OP_STORE) mem_we = 1'b1;
        if (k_q == x) st_d = (cmd_i.op == OP_STORE) ? ST_DONE : ST_WAIT;
        else k_d = k_q + 4'd1;
      end
      ST_WAIT: st_d = ST_DONE;
      ST_DONE: begin
        done_o = 1'b1;
        pop_o = 1'b1;
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // flag write wins over the result when VF is the destination
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; pc_q <= PcReset; i_q <= '0; sp_q <= '0;
      dt_q <= '0; st8_q <= '0; k_q <= '0; fault_q <= 1'b0; ldw_q <= 1'b0; kw_q <= '0;
      for (int r = 0; r < 16; r++) v_q[r] <= '0;
    end else begin
      st_q <= st_d; pc_q <= pc_d; i_q <= i_d; sp_q <= sp_d;
      dt_q <= dt_d; st8_q <= st8_d; k_q <= k_d; fault_q <= fault_d;
      ldw_q <= (st_q == ST_MEM) && (cmd_i.op == OP_LOAD);
      kw_q <= k_q;
      if (reg_we && !(vf_we && reg_a == 4'hf)) v_q[reg_a] <= reg_v;
      if (vf_we) v_q[15] <= vf_v;
      if (ldw_q) v_q[kw_q] <= rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_q[SiW'(sp_q)] <= pc2;
    if (mem_we) mem_q[mem_a] <= mem_v;
    rdata_q <= mem_q[mem_a];
  end

  always_comb begin
    result_o.next_pc = pc_q;
    result_o.index_value = i_q;
    result_o.matched = cmd_i.matched;
    result_o.clear_display = (cmd_i.op == OP_CLS);
    result_o.sound_level = st8_q;
    result_o.stack_fault = fault_q;
  end
endmodule

// ===== rtl/core/vm_opcode_execute_unit_top.sv =====
// Top level of the VM opcode execute unit.
//  channel | direction | transfer
//  item    | in        | start && !busy at clk edge, payload in_i
//  result  | out       | done_o high one cycle, payload result_o
// Block store and load go through the single data memory port, stepping one register a cycle.
// A two-entry queue lets the front take items while the back end works.
// Reset clears all control state; pc resets to 512. Results cannot be stalled.
module vm_opcode_execute_unit_top import voe_pkg::*; #(
  parameter int STACK_DEPTH = StackDepthDef,
  parameter int MEMORY_BYTES = MemoryBytesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output logic done_o,
  output out_t result_o
);
  logic pop, cv;
  cmd_t cmd;

  voe_front u_front (
    .clk_i, .rst_ni, .start, .busy, .in_i,
    .pop_i(pop), .cmd_valid_o(cv), .cmd_o(cmd)
  );

  voe_back #(.STACK_DEPTH(STACK_DEPTH), .MEMORY_BYTES(MEMORY_BYTES)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cv), .cmd_i(cmd),
    .pop_o(pop), .done_o, .result_o
  );
endmodule
